@@ rtl/smte_pkg.sv @@
package smte_pkg;

    // Tick counters and deltas are 23 bits wide and saturate at the top.
    localparam int TICK_W = 23;
    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // Register widths and reset values.
    localparam int TEMPO_W = 24;
    localparam int STEP_W  = 14;
    localparam logic [TEMPO_W-1:0] TEMPO_RESET = 24'd500000;
    localparam logic [STEP_W-1:0]  STEP_TICKS_RESET = 14'd120;
    localparam logic [STEP_W-1:0]  NOTE_LEN_RESET   = 14'd105;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_TEMPO    = 2'd0;
    localparam logic [1:0] REG_STEP     = 2'd1;
    localparam logic [1:0] REG_NOTE_LEN = 2'd2;
    localparam int PADDR_W = 4;

    // MIDI codes.
    localparam logic [7:0] MIDI_NOTE_ON   = 8'h90;
    localparam logic [7:0] MIDI_NOTE_OFF  = 8'h80;
    localparam logic [7:0] MIDI_META      = 8'hFF;
    localparam logic [7:0] META_TEMPO     = 8'h51;
    localparam logic [7:0] META_TIME_SIG  = 8'h58;
    localparam logic [7:0] META_END_TRACK = 8'h2F;
    localparam logic [7:0] MIDI_ZERO      = 8'h00;

    // Byte slots of one item, in the order they leave the block.
    localparam int SLOT_W    = 6;
    localparam int NUM_SLOTS = 34;
    localparam int HDR_LEN   = 15;
    localparam logic [SLOT_W-1:0] SLOT_HDR      = 6'd0;
    localparam logic [SLOT_W-1:0] SLOT_ON_DELTA = 6'd15;
    localparam logic [SLOT_W-1:0] SLOT_ON       = 6'd19;
    localparam logic [SLOT_W-1:0] SLOT_LEN      = 6'd22;
    localparam logic [SLOT_W-1:0] SLOT_OFF      = 6'd24;
    localparam logic [SLOT_W-1:0] SLOT_CLOSE    = 6'd27;
    localparam logic [SLOT_W-1:0] SLOT_EOT      = 6'd31;

    // Everything the byte sequencer needs to know about one item.
    typedef struct packed {
        logic [TEMPO_W-1:0] tempo;
        logic [TICK_W-1:0]  on_delta;
        logic [6:0]         note;
        logic [6:0]         velocity;
        logic [STEP_W-1:0]  note_len;
        logic [TICK_W-1:0]  close_delta;
    } smte_plan_t;

    typedef struct packed {
        logic busy;
        logic take;
    } smte_status_t;

    // Tempo and time signature meta events, both at delta zero.
    function automatic logic [7:0] hdr_byte(input logic [3:0] idx,
                                            input logic [TEMPO_W-1:0] tempo);
        logic [7:0] b;
        case (idx)
            4'd0:    b = MIDI_ZERO;
            4'd1:    b = MIDI_META;
            4'd2:    b = META_TEMPO;
            4'd3:    b = 8'h03;
            4'd4:    b = tempo[23:16];
            4'd5:    b = tempo[15:8];
            4'd6:    b = tempo[7:0];
            4'd7:    b = MIDI_ZERO;
            4'd8:    b = MIDI_META;
            4'd9:    b = META_TIME_SIG;
            4'd10:   b = 8'h04;
            4'd11:   b = 8'h04;
            4'd12:   b = 8'h02;
            4'd13:   b = 8'h18;
            4'd14:   b = 8'h08;
            default: b = MIDI_ZERO;
        endcase
        return b;
    endfunction

    // Group k of a variable-length quantity; every group but the lowest
    // carries the continuation bit.
    function automatic logic [7:0] vlq_byte(input logic [TICK_W-1:0] v,
                                            input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = {1'b0, v[6:0]};
            2'd1:    b = {1'b1, v[13:7]};
            2'd2:    b = {1'b1, v[20:14]};
            2'd3:    b = {1'b1, 5'd0, v[22:21]};
            default: b = MIDI_ZERO;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/smte_emit.sv @@
// Byte sequencer: holds the plan of one item and a mask of the byte slots
// still to send, and sends the lowest pending slot each cycle unless m_ready stalls it.
module smte_emit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                load,
    input  smte_pkg::smte_plan_t                plan,
    input  logic [smte_pkg::NUM_SLOTS-1:0]      slot_mask,
    output smte_pkg::smte_status_t              status,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_track_byte,
    output logic                                m_run_end
);

    logic                               busy_reg;
    logic [smte_pkg::NUM_SLOTS-1:0]     mask_reg;
    smte_pkg::smte_plan_t               plan_reg;
    logic                               m_valid_reg;
    logic [7:0]                         m_byte_reg;
    logic                               m_run_end_reg;

    logic [smte_pkg::SLOT_W-1:0]        sel;
    logic [smte_pkg::NUM_SLOTS-1:0]     mask_next;
    logic [7:0]                         byte_next;
    logic                               fire;
    logic                               last;

    // Lowest pending slot.
    always_comb begin
        sel = '0;
        for (int i = smte_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                sel = smte_pkg::SLOT_W'(i);
            end
        end
    end

    assign mask_next = mask_reg & ~(smte_pkg::NUM_SLOTS'(1) << sel);
    assign last      = (mask_next == '0);
    assign fire      = busy_reg && (!m_valid_reg || m_ready);

    // Byte value of the selected slot.
    always_comb begin
        if (sel < smte_pkg::SLOT_ON_DELTA) begin
            byte_next = smte_pkg::hdr_byte(4'(sel), plan_reg.tempo);
        end else if (sel < smte_pkg::SLOT_ON) begin
            byte_next = smte_pkg::vlq_byte(plan_reg.on_delta,
                                           2'(smte_pkg::SLOT_ON - 6'd1 - sel));
        end else if (sel == smte_pkg::SLOT_ON) begin
            byte_next = smte_pkg::MIDI_NOTE_ON;
        end else if (sel == smte_pkg::SLOT_ON + 6'd1) begin
            byte_next = {1'b0, plan_reg.note};
        end else if (sel == smte_pkg::SLOT_ON + 6'd2) begin
            byte_next = {1'b0, plan_reg.velocity};
        end else if (sel < smte_pkg::SLOT_OFF) begin
            byte_next = smte_pkg::vlq_byte(
                {{(smte_pkg::TICK_W - smte_pkg::STEP_W){1'b0}}, plan_reg.note_len},
                2'(smte_pkg::SLOT_OFF - 6'd1 - sel));
        end else if (sel == smte_pkg::SLOT_OFF) begin
            byte_next = smte_pkg::MIDI_NOTE_OFF;
        end else if (sel == smte_pkg::SLOT_OFF + 6'd1) begin
            byte_next = {1'b0, plan_reg.note};
        end else if (sel == smte_pkg::SLOT_OFF + 6'd2) begin
            byte_next = smte_pkg::MIDI_ZERO;
        end else if (sel < smte_pkg::SLOT_EOT) begin
            byte_next = smte_pkg::vlq_byte(plan_reg.close_delta,
                                           2'(smte_pkg::SLOT_EOT - 6'd1 - sel));
        end else if (sel == smte_pkg::SLOT_EOT) begin
            byte_next = smte_pkg::MIDI_META;
        end else if (sel == smte_pkg::SLOT_EOT + 6'd1) begin
            byte_next = smte_pkg::META_END_TRACK;
        end else begin
            byte_next = smte_pkg::MIDI_ZERO;
        end
    end

    // A new item is taken when the sequencer is empty or sends its last byte.
    assign status.busy = busy_reg;
    assign status.take = !busy_reg || (fire && last);

    // Sequencer control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            mask_reg <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            mask_reg <= slot_mask;
        end else if (fire) begin
            busy_reg <= !last;
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            plan_reg <= plan;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_byte_reg    <= byte_next;
            m_run_end_reg <= last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_track_byte = m_byte_reg;
    assign m_run_end    = m_run_end_reg;

endmodule

@@ rtl/step_pattern_midi_track_encoder.sv @@
// Step-pattern MIDI track encoder. Each accepted step item is turned into the
// bytes of a MIDI track body, sent one byte per cycle on the m_ channel unless
// m_ready stalls it, with m_run_end marking the last byte of the item. An item
// produces 15 bytes for the tempo and time signature header on the first step
// of a track, up to 12 for a played note and up to 7 for the end-of-track on
// the final step, so at most 34; a quiet step that is neither first nor final
// produces nothing. The rate is set by the single byte-wide output register;
// the next item is taken in the cycle the last byte of the current one is sent,
// so bytes of consecutive items follow without a gap. Tempo, ticks per step
// and note length are written through the APB port at byte addresses 0, 4 and
// 8; the user must write them only while idle, as the block does not enforce it.
module step_pattern_midi_track_encoder (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [smte_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // Step items
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_note_active,
    input  logic [6:0]                      s_note_number,
    input  logic [6:0]                      s_note_velocity,
    input  logic                            s_final_step,
    // Track bytes
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_track_byte,
    output logic                            m_run_end
);

    localparam int TW = smte_pkg::TICK_W;
    localparam int SW = smte_pkg::STEP_W;

    logic [smte_pkg::TEMPO_W-1:0]   tempo_reg;
    logic [SW-1:0]                  step_ticks_reg;
    logic [SW-1:0]                  note_len_reg;

    logic                           started_reg;
    logic [TW-1:0]                  step_start_reg;
    logic [TW-1:0]                  last_tick_reg;

    logic                           cfg_write;
    logic                           accept;
    logic                           hdr;
    logic [TW-1:0]                  ss;
    logic [TW-1:0]                  le;
    logic [TW-1:0]                  on_delta;
    logic [TW:0]                    end_sum;
    logic [TW-1:0]                  note_end;
    logic [TW-1:0]                  le_after;
    logic [TW:0]                    total_sum;
    logic [TW-1:0]                  total;
    logic [TW-1:0]                  close_delta;
    logic [smte_pkg::NUM_SLOTS-1:0] slot_mask;
    smte_pkg::smte_plan_t           plan;
    smte_pkg::smte_status_t         status;

    // Register writes and reads.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tempo_reg      <= smte_pkg::TEMPO_RESET;
            step_ticks_reg <= smte_pkg::STEP_TICKS_RESET;
            note_len_reg   <= smte_pkg::NOTE_LEN_RESET;
        end else if (cfg_write) begin
            case (paddr[3:2])
                smte_pkg::REG_TEMPO:    tempo_reg      <= pwdata[23:0];
                smte_pkg::REG_STEP:     step_ticks_reg <= pwdata[SW-1:0];
                smte_pkg::REG_NOTE_LEN: note_len_reg   <= pwdata[SW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            smte_pkg::REG_TEMPO:    prdata = {8'd0, tempo_reg};
            smte_pkg::REG_STEP:     prdata = {{(32 - SW){1'b0}}, step_ticks_reg};
            smte_pkg::REG_NOTE_LEN: prdata = {{(32 - SW){1'b0}}, note_len_reg};
            default:                prdata = '0;
        endcase
    end

    // Tick arithmetic for the incoming step. A new track starts at tick zero.
    assign hdr      = !started_reg;
    assign ss       = hdr ? '0 : step_start_reg;
    assign le       = hdr ? '0 : last_tick_reg;
    assign on_delta = (ss > le) ? ss - le : '0;

    assign end_sum  = {1'b0, ss} + {{(TW + 1 - SW){1'b0}}, note_len_reg};
    assign note_end = end_sum[TW] ? smte_pkg::TICK_MAX : end_sum[TW-1:0];
    assign le_after = s_note_active ? note_end : le;

    assign total_sum   = {1'b0, ss} + {{(TW + 1 - SW){1'b0}}, step_ticks_reg};
    assign total       = total_sum[TW] ? smte_pkg::TICK_MAX : total_sum[TW-1:0];
    assign close_delta = (le_after < total) ? total - le_after : '0;

    // Which byte slots this step fills.
    always_comb begin
        slot_mask = '0;
        slot_mask[smte_pkg::SLOT_HDR +: smte_pkg::HDR_LEN] = {smte_pkg::HDR_LEN{hdr}};
        slot_mask[smte_pkg::SLOT_ON_DELTA]        = s_note_active && (on_delta[22:21] != '0);
        slot_mask[smte_pkg::SLOT_ON_DELTA + 6'd1] = s_note_active && (on_delta[22:14] != '0);
        slot_mask[smte_pkg::SLOT_ON_DELTA + 6'd2] = s_note_active && (on_delta[22:7] != '0);
        slot_mask[smte_pkg::SLOT_ON_DELTA + 6'd3] = s_note_active;
        slot_mask[smte_pkg::SLOT_ON +: 3]         = {3{s_note_active}};
        slot_mask[smte_pkg::SLOT_LEN]             = s_note_active && (note_len_reg[13:7] != '0);
        slot_mask[smte_pkg::SLOT_LEN + 6'd1]      = s_note_active;
        slot_mask[smte_pkg::SLOT_OFF +: 3]        = {3{s_note_active}};
        slot_mask[smte_pkg::SLOT_CLOSE]           = s_final_step && (close_delta[22:21] != '0);
        slot_mask[smte_pkg::SLOT_CLOSE + 6'd1]    = s_final_step && (close_delta[22:14] != '0);
        slot_mask[smte_pkg::SLOT_CLOSE + 6'd2]    = s_final_step && (close_delta[22:7] != '0);
        slot_mask[smte_pkg::SLOT_CLOSE + 6'd3]    = s_final_step;
        slot_mask[smte_pkg::SLOT_EOT +: 3]        = {3{s_final_step}};
    end

    always_comb begin
        plan.tempo       = tempo_reg;
        plan.on_delta    = on_delta;
        plan.note        = s_note_number;
        plan.velocity    = s_note_velocity;
        plan.note_len    = note_len_reg;
        plan.close_delta = close_delta;
    end

    assign s_ready = status.take;
    assign accept  = s_valid && s_ready;

    // Track position; the final step returns everything to a fresh track.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg    <= 1'b0;
            step_start_reg <= '0;
            last_tick_reg  <= '0;
        end else if (accept) begin
            if (s_final_step) begin
                started_reg    <= 1'b0;
                step_start_reg <= '0;
                last_tick_reg  <= '0;
            end else begin
                started_reg    <= 1'b1;
                step_start_reg <= total;
                last_tick_reg  <= le_after;
            end
        end
    end

    smte_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (accept && (slot_mask != '0)),
        .plan         (plan),
        .slot_mask    (slot_mask),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_track_byte (m_track_byte),
        .m_run_end    (m_run_end)
    );

    // A track that has not started carries no tick position.
    a_idle_ticks: assert property (@(posedge aclk) disable iff (!aresetn)
        !started_reg |-> (step_start_reg == '0) && (last_tick_reg == '0))
        else $error("tick state not cleared outside a track");

    // A final step always closes the track.
    a_final_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_final_step |=> !started_reg)
        else $error("track still open after final step");

    // A busy sequencer takes a new item only as it sends its last byte.
    a_take_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        status.busy && s_ready |=> m_valid && m_run_end)
        else $error("item taken while previous item still had bytes");

endmodule
